>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; both sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/rtcm_pkg.sv
// ----------------------------------------------------------------------------
// rtcm_pkg
// Shared types and constants of the RTCM3 frame sync / CRC24Q block.
// ----------------------------------------------------------------------------
package rtcm_pkg;

    localparam logic [7:0]  PREAMBLE     = 8'hD3;
    localparam logic [23:0] CRC_POLY     = 24'h864CFB;
    localparam int          HDR_LEN      = 3;
    localparam int          CRC_LEN      = 3;
    localparam int          RESULT_LIMIT = 64;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRE,
        ST_HDR1,
        ST_HDR2,
        ST_CRC,
        ST_RX0,
        ST_RX1,
        ST_RX2,
        ST_MATCH,
        ST_DONE
    } seq_state_t;

    // Control of the shared CRC unit
    typedef struct packed {
        logic clr;
        logic en;
    } crc_ctl_t;

endpackage

>>> rtl/rtcm_byte_if.sv
// ----------------------------------------------------------------------------
// rtcm_byte_if
// Input channel: one raw stream byte per request.
// ----------------------------------------------------------------------------
interface rtcm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/rtcm_frame_if.sv
// ----------------------------------------------------------------------------
// rtcm_frame_if
// Output channel: one verified frame descriptor per request.
// ----------------------------------------------------------------------------
interface rtcm_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_offset;
    logic [10:0] frame_length;
    logic [9:0]  body_length;
    logic [11:0] message_type;
    logic        last_of_run;

    modport source (output valid, output frame_offset, output frame_length,
                    output body_length, output message_type, output last_of_run,
                    input ready);
    modport sink   (input valid, input frame_offset, input frame_length,
                    input body_length, input message_type, input last_of_run,
                    output ready);
endinterface

>>> rtl/rtcm3_frame_sync_crc24q_top.sv
// ----------------------------------------------------------------------------
// rtcm3_frame_sync_crc24q_top
// RTCM3 deframer: preamble hunt, length decode, CRC24Q check per frame.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in   : one stream byte per request; ready only while the sequencer
//               is idle.
//   frame_out : one descriptor per frame whose CRC matches, up to 64 per input
//               byte; last_of_run marks the last descriptor of that byte.
// Timing: each byte is written to the ring store, then the pending bytes are
//   rescanned by a sequencer with a single read port and one shared CRC unit.
//   The scan drops non-preamble bytes one at a time. A complete candidate
//   passes all but its three CRC bytes through the CRC unit, then the three
//   received CRC bytes are compared; a CRC mismatch restarts the scan one
//   byte later. The last result of a byte goes out when the scan of that byte
//   ends; an earlier result goes out when the next frame from the same byte is
//   confirmed.
// Reset: buffer empty, stream position zero, no result pending; the store
//   itself is not cleared.
// Stall: a held result blocks the sequencer only when a further result must
//   be loaded; the next input byte is accepted while the last one waits.
// ----------------------------------------------------------------------------
module rtcm3_frame_sync_crc24q_top
    import rtcm_pkg::*;
#(
    parameter int STORE_DEPTH   = 2048,
    parameter int MIN_FRAME_LEN = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    rtcm_byte_if.sink     byte_in,
    rtcm_frame_if.source  frame_out
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = $clog2(STORE_DEPTH + 1);
    localparam int CW = $clog2(RESULT_LIMIT + 1);

    // Ring add of an offset below the depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [10:0]   off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(off);
        if (sum >= (AW+1)'(STORE_DEPTH))
        begin
            sum = sum - (AW+1)'(STORE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    seq_state_t state_reg, state_next;

    logic [AW-1:0] sp_reg, sp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic [31:0]   pos_reg, pos_next;
    logic [9:0]    len_reg, len_next;
    logic [10:0]   off_reg, off_next;
    logic          ok_reg, ok_next;
    logic [11:0]   mt_reg, mt_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic          held_valid_reg, held_valid_next;
    logic [31:0]   held_off_reg, held_off_next;
    logic [9:0]    held_len_reg, held_len_next;
    logic [11:0]   held_mt_reg, held_mt_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_off_reg, out_off_next;
    logic [9:0]    out_len_reg, out_len_next;
    logic [11:0]   out_mt_reg, out_mt_next;
    logic          out_last_reg, out_last_next;

    logic [10:0]   flen;
    logic [10:0]   rd_off;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          accept;
    logic          out_free;
    logic          crc_ok;
    crc_ctl_t      crc_ctl;
    logic [23:0]   crc_val;

    assign flen     = {1'b0, len_reg} + 11'd6;
    assign accept   = byte_in.valid && byte_in.ready;
    assign out_free = !out_valid_reg || frame_out.ready;
    assign crc_ok   = ok_reg && (rd_data == crc_val[7:0]);
    assign rd_addr  = ring_add(sp_reg, rd_off);

    rtcm_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (byte_in.data_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    rtcm_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (rd_data),
        .crc   (crc_val)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SCAN;
            ST_SCAN:  state_next = (pend_reg == '0) ? ST_DONE : ST_PRE;
            ST_PRE:
            begin
                if (rd_data != PREAMBLE)
                begin
                    state_next = ST_SCAN;
                end
                else if (pend_reg < PW'(HDR_LEN))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_HDR1;
                end
            end
            ST_HDR1:  state_next = ST_HDR2;
            ST_HDR2:
            begin
                priority if (pend_reg < PW'({1'b0, len_reg[9:8], rd_data} + 11'd6))
                begin
                    state_next = ST_DONE;
                end
                else if (({len_reg[9:8], rd_data} + 11'd6) < 11'(MIN_FRAME_LEN))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_CRC;
                end
            end
            ST_CRC:   if (off_reg == flen - 11'(CRC_LEN + 1)) state_next = ST_RX0;
            ST_RX0:   state_next = ST_RX1;
            ST_RX1:   state_next = ST_RX2;
            ST_RX2:   state_next = crc_ok ? ST_MATCH : ST_SCAN;
            ST_MATCH:
            begin
                if (cnt_reg == CW'(RESULT_LIMIT) || !held_valid_reg || out_free)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:  if (!held_valid_reg || out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sp_next         = sp_reg;
        wp_next         = wp_reg;
        pend_next       = pend_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        ok_next         = ok_reg;
        mt_next         = mt_reg;
        cnt_next        = cnt_reg;
        held_valid_next = held_valid_reg;
        held_off_next   = held_off_reg;
        held_len_next   = held_len_reg;
        held_mt_next    = held_mt_reg;
        out_valid_next  = out_valid_reg && !frame_out.ready;
        out_off_next    = out_off_reg;
        out_len_next    = out_len_reg;
        out_mt_next     = out_mt_reg;
        out_last_next   = out_last_reg;
        rd_off          = 11'd0;
        crc_ctl         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next   = ring_add(wp_reg, 11'd1);
                    pend_next = pend_reg + PW'(1);
                    pos_next  = pos_reg + 32'd1;
                end
            end
            ST_SCAN:
            begin
                rd_off = 11'd0;
            end
            ST_PRE:
            begin
                rd_off = 11'd1;
                if (rd_data != PREAMBLE)
                begin
                    sp_next   = ring_add(sp_reg, 11'd1);
                    pend_next = pend_reg - PW'(1);
                end
            end
            ST_HDR1:
            begin
                rd_off   = 11'd2;
                len_next = {rd_data[1:0], 8'h00};
            end
            ST_HDR2:
            begin
                rd_off      = 11'd0;
                len_next    = {len_reg[9:8], rd_data};
                off_next    = 11'd0;
                mt_next     = '0;
                crc_ctl.clr = 1'b1;
                if (({len_reg[9:8], rd_data} + 11'd6) < 11'(MIN_FRAME_LEN)
                    && pend_reg >= PW'({len_reg[9:8], rd_data} + 11'd6))
                begin
                    sp_next   = ring_add(sp_reg, 11'd1);
                    pend_next = pend_reg - PW'(1);
                end
            end
            ST_CRC:
            begin
                crc_ctl.en = 1'b1;
                rd_off     = off_reg + 11'd1;
                off_next   = off_reg + 11'd1;
                if (off_reg == 11'd3) mt_next[11:4] = rd_data;
                if (off_reg == 11'd4) mt_next[3:0]  = rd_data[7:4];
            end
            ST_RX0:
            begin
                rd_off   = off_reg + 11'd1;
                off_next = off_reg + 11'd1;
                ok_next  = (rd_data == crc_val[23:16]);
            end
            ST_RX1:
            begin
                rd_off   = off_reg + 11'd1;
                off_next = off_reg + 11'd1;
                ok_next  = ok_reg && (rd_data == crc_val[15:8]);
            end
            ST_RX2:
            begin
                if (!crc_ok)
                begin
                    sp_next   = ring_add(sp_reg, 11'd1);
                    pend_next = pend_reg - PW'(1);
                end
            end
            ST_MATCH:
            begin
                if (cnt_reg == CW'(RESULT_LIMIT) || !held_valid_reg || out_free)
                begin
                    sp_next   = ring_add(sp_reg, flen);
                    pend_next = pend_reg - PW'(flen);
                    if (cnt_reg != CW'(RESULT_LIMIT))
                    begin
                        // older result goes out, new one waits in the hold stage
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_off_next   = held_off_reg;
                            out_len_next   = held_len_reg;
                            out_mt_next    = held_mt_reg;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_off_next   = pos_reg - 32'(pend_reg);
                        held_len_next   = len_reg;
                        held_mt_next    = (len_reg >= 10'd2) ? mt_reg : 12'h000;
                        cnt_next        = cnt_reg + CW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!held_valid_reg || out_free)
                begin
                    cnt_next = '0;
                    if (held_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_off_next    = held_off_reg;
                        out_len_next    = held_len_reg;
                        out_mt_next     = held_mt_reg;
                        out_last_next   = 1'b1;
                        held_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                rd_off = 11'd0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sp_reg         <= '0;
            wp_reg         <= '0;
            pend_reg       <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            wp_reg         <= wp_next;
            pend_reg       <= pend_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        off_reg      <= off_next;
        ok_reg       <= ok_next;
        mt_reg       <= mt_next;
        held_off_reg <= held_off_next;
        held_len_reg <= held_len_next;
        held_mt_reg  <= held_mt_next;
        out_off_reg  <= out_off_next;
        out_len_reg  <= out_len_next;
        out_mt_reg   <= out_mt_next;
        out_last_reg <= out_last_next;
    end

    assign byte_in.ready          = (state_reg == ST_IDLE);
    assign frame_out.valid        = out_valid_reg;
    assign frame_out.frame_offset = out_off_reg;
    assign frame_out.frame_length = {1'b0, out_len_reg} + 11'd6;
    assign frame_out.body_length  = out_len_reg;
    assign frame_out.message_type = out_mt_reg;
    assign frame_out.last_of_run  = out_last_reg;

endmodule

>>> rtl/rtcm_store.sv
// ----------------------------------------------------------------------------
// rtcm_store
// Byte ring buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtcm_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/rtcm_crc.sv
// ----------------------------------------------------------------------------
// rtcm_crc
// CRC24Q accumulator, one byte per enabled cycle, MSB first.
// ----------------------------------------------------------------------------
module rtcm_crc
    import rtcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    input  logic [7:0]  data,
    output logic [23:0] crc
);

    logic [23:0] crc_reg;
    logic [23:0] crc_next;

    // Eight bit steps of the polynomial division
    always_comb
    begin
        logic [23:0] c;
        c = crc_reg ^ {data, 16'h0000};
        for (int b = 0; b < 8; b++)
        begin
            c = {c[22:0], 1'b0} ^ (c[23] ? CRC_POLY : 24'h000000);
        end
        crc_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (ctl.clr)
        begin
            crc_reg <= '0;
        end
        else if (ctl.en)
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> rtl/rtcm_chk.sv
// ----------------------------------------------------------------------------
// rtcm_chk
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcm_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_offset,
    input logic [10:0] out_flen,
    input logic [9:0]  out_body,
    input logic        out_last
);

    // a request starts a scan, so the input closes right after
    `CHK_NEXT(a_in_busy, in_valid && in_ready, !in_ready)
    // more results of the same byte are still to come
    `CHK_SAME(a_mid_run, out_valid && !out_last, !in_ready)
    // frame length is header plus body plus CRC
    `CHK_SAME(a_len, out_valid, out_flen == 11'(out_body) + 11'd6)
    // a stalled result holds
    `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_offset))

endmodule

bind rtcm3_frame_sync_crc24q_top rtcm_chk u_rtcm_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .out_valid  (frame_out.valid),
    .out_ready  (frame_out.ready),
    .out_offset (frame_out.frame_offset),
    .out_flen   (frame_out.frame_length),
    .out_body   (frame_out.body_length),
    .out_last   (frame_out.last_of_run)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raw RTCM3 stream bytes into rtcm3_frame_sync_crc24q_top and checks
// every frame descriptor against a byte-level deframer with CRC24Q in the
// bench. A directed table covers length extremes, bad CRCs, junk and a run
// of more than 64 frames closed by one byte. Random frames, junk and cut
// frames follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcm_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 300;

    typedef enum int {FR_GOOD, FR_BADCRC, FR_JUNK, FR_CUT, FR_BURST} frame_kind_t;

    typedef struct {
        frame_kind_t kind;
        int          body_bytes;
        logic [5:0]  hdr_hi;
        logic [11:0] msg;
    } stim_row_t;

    typedef struct {
        logic [31:0] offset;
        logic [10:0] flen;
        logic [9:0]  blen;
        logic [11:0] mtype;
        logic        last;
    } frame_desc_t;

    logic clk;
    logic rst_n;

    rtcm_byte_if  byte_in ();
    rtcm_frame_if frame_out ();

    rtcm3_frame_sync_crc24q_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in.sink),
        .frame_out (frame_out.source)
    );

    // Bench copy of the deframer state
    logic [7:0]  pending_bytes[$];
    int unsigned stream_pos;
    frame_desc_t frames_due[$];
    frame_desc_t last_found;
    int          found_now;

    int  errors;
    int  bytes_sent;
    int  frames_checked;
    int  frames_found;
    int  cycle_count;
    int  hold_left;
    bit  quiet;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d frames still due", $realtime, frames_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // CRC24Q over the first n bytes of a queue
    function automatic logic [23:0] crc24q(ref logic [7:0] q[$], input int n);
        logic [24:0] crc;
        crc = '0;
        for (int k = 0; k < n; k++)
        begin
            crc = crc ^ (25'(q[k]) << 16);
            for (int b = 0; b < 8; b++)
            begin
                crc = crc << 1;
                if (crc[24])
                    crc = crc ^ {1'b1, CRC_POLY};
            end
        end
        return crc[23:0];
    endfunction

    // Append one byte and pull out every frame it completes
    function automatic void deframe_byte(input logic [7:0] b);
        frame_desc_t found[$];
        frame_desc_t fd;
        int          npend;
        int          flen;
        logic [9:0]  blen;
        logic [23:0] rx;
        int          total;
        total = 0;
        pending_bytes.push_back(b);
        stream_pos = stream_pos + 1;
        forever
        begin
            npend = pending_bytes.size();
            if (npend == 0)
                break;
            if (pending_bytes[0] != PREAMBLE)
            begin
                void'(pending_bytes.pop_front());
                continue;
            end
            if (npend < HDR_LEN)
                break;
            blen = {pending_bytes[1][1:0], pending_bytes[2]};
            flen = int'(blen) + HDR_LEN + CRC_LEN;
            if (npend < flen)
                break;
            rx = {pending_bytes[flen-3], pending_bytes[flen-2], pending_bytes[flen-1]};
            if (rx != crc24q(pending_bytes, flen - 3))
            begin
                // mismatch: drop the preamble only and rescan
                void'(pending_bytes.pop_front());
                continue;
            end
            if (total < RESULT_LIMIT)
            begin
                fd.offset = stream_pos - npend;
                fd.flen   = 11'(flen);
                fd.blen   = blen;
                fd.mtype  = (blen >= 2) ? {pending_bytes[3], pending_bytes[4][7:4]} : 12'd0;
                fd.last   = 1'b0;
                found.push_back(fd);
            end
            total++;
            pending_bytes = pending_bytes[flen:$];
        end
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            frames_due.push_back(found[i]);
        found_now = found.size();
        frames_found += found.size();
        if (found.size() > 0)
            last_found = found[found.size()-1];
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // One request on the byte channel; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_in.valid     <= 1'b1;
        byte_in.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_in.ready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Build and send one frame; a bad frame gets a CRC that cannot match
    task automatic send_frame(input int blen, input logic [5:0] hi, input logic [11:0] msg,
                              input bit bad, input bit rnd_body, input int cut_at);
        logic [7:0]  fb[$];
        logic [23:0] crc;
        fb.push_back(PREAMBLE);
        fb.push_back({hi, 2'(blen >> 8)});
        fb.push_back(8'(blen));
        for (int i = 0; i < blen; i++)
        begin
            if (rnd_body)
                fb.push_back(8'($urandom));
            else
                fb.push_back(8'(i * 37 + 1));
        end
        if (blen >= 1)
            fb[3] = msg[11:4];
        if (blen >= 2)
            fb[4] = {msg[3:0], fb[4][3:0]};
        crc = crc24q(fb, fb.size());
        if (bad)
            crc = (crc == 24'd0) ? 24'h010101 : 24'd0;
        fb.push_back(crc[23:16]);
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        if (cut_at > 0 && cut_at < fb.size())
            fb = fb[0:cut_at-1];
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    // Preamble with a long bad frame that hides more than 64 empty frames
    task automatic send_burst();
        logic [7:0] inner[$];
        logic [23:0] crc;
        inner = '{PREAMBLE, 8'h00, 8'h00};
        crc = crc24q(inner, 3);
        send_byte(PREAMBLE);
        send_byte(8'hFD);
        send_byte(8'h86);
        for (int f = 0; f < 65; f++)
        begin
            foreach (inner[i])
                send_byte(inner[i]);
            send_byte(crc[23:16]);
            send_byte(crc[15:8]);
            send_byte(crc[7:0]);
        end
        // receiver holds off while the burst of frames piles up
        hold_left = HOLD_CYCLES;
        repeat (3) send_byte(8'h00);
    endtask

    task automatic send_junk(input int n, input bit rnd);
        logic [7:0] fixed[4];
        fixed = '{8'h00, 8'hFF, 8'hAA, 8'hD2};
        for (int i = 0; i < n; i++)
            send_byte(rnd ? 8'($urandom) : fixed[i % 4]);
    endtask

    // Result channel backpressure
    initial
    begin
        int stall_left;
        stall_left      = 0;
        frame_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                frame_out.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                frame_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                frame_out.ready <= 1'b1;
                if (!quiet && $urandom_range(5) == 0)
                    stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                          : $urandom_range(3, 1);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        frame_desc_t e;
        if (rst_n && frame_out.valid && frame_out.ready)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected frame offset=%0d exp=none act=%0d", $realtime,
                         frame_out.frame_offset, frame_out.frame_offset);
                errors++;
            end
            else
            begin
                e = frames_due.pop_front();
                frames_checked++;
                if (frame_out.frame_offset !== e.offset)
                begin
                    $display("%0t: frame_offset exp=%0d act=%0d", $realtime, e.offset,
                             frame_out.frame_offset);
                    errors++;
                end
                if (frame_out.frame_length !== e.flen)
                begin
                    $display("%0t: frame_length exp=%0d act=%0d", $realtime, e.flen,
                             frame_out.frame_length);
                    errors++;
                end
                if (frame_out.body_length !== e.blen)
                begin
                    $display("%0t: body_length exp=%0d act=%0d", $realtime, e.blen,
                             frame_out.body_length);
                    errors++;
                end
                if (frame_out.message_type !== e.mtype)
                begin
                    $display("%0t: message_type exp=%0d act=%0d", $realtime, e.mtype,
                             frame_out.message_type);
                    errors++;
                end
                if (frame_out.last_of_run !== e.last)
                begin
                    $display("%0t: last_of_run exp=%0b act=%0b", $realtime, e.last,
                             frame_out.last_of_run);
                    errors++;
                end
            end
        end
    end

    // Directed table
    stim_row_t directed[10] = '{
        '{FR_GOOD,   0,    6'h00, 12'h000},
        '{FR_GOOD,   1,    6'h00, 12'hFFF},
        '{FR_GOOD,   2,    6'h00, 12'hFFF},
        '{FR_GOOD,   3,    6'h3F, 12'h000},
        '{FR_JUNK,   6,    6'h00, 12'h000},
        '{FR_BADCRC, 4,    6'h00, 12'h123},
        '{FR_GOOD,   5,    6'h2A, 12'hABC},
        '{FR_GOOD,   1023, 6'h15, 12'd1005},
        '{FR_BURST,  0,    6'h00, 12'h000},
        '{FR_GOOD,   10,   6'h00, 12'd1077}
    };

    // Stimulus
    initial
    begin
        int          rnd_start;
        int          found_start;
        int          k;
        logic [11:0] want_mt;
        errors            = 0;
        bytes_sent        = 0;
        frames_checked    = 0;
        frames_found      = 0;
        cycle_count       = 0;
        hold_left         = 0;
        quiet             = 1'b0;
        stream_pos        = 0;
        rst_n             = 1'b0;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            case (directed[i].kind)
                FR_JUNK:   send_junk(directed[i].body_bytes, 1'b0);
                FR_BADCRC: send_frame(directed[i].body_bytes, directed[i].hdr_hi,
                                      directed[i].msg, 1'b1, 1'b0, 0);
                FR_BURST:
                begin
                    send_burst();
                end
                default:
                begin
                    send_frame(directed[i].body_bytes, directed[i].hdr_hi,
                               directed[i].msg, 1'b0, 1'b0, 0);
                    want_mt = (directed[i].body_bytes >= 2) ? directed[i].msg : 12'd0;
                    if (found_now != 1 || last_found.flen != directed[i].body_bytes + 6
                        || last_found.mtype != want_mt)
                    begin
                        $display("%0t: row %0d exp len=%0d type=%0d act len=%0d type=%0d",
                                 $realtime, i, directed[i].body_bytes + 6, want_mt,
                                 last_found.flen, last_found.mtype);
                        errors++;
                    end
                end
            endcase
        end

        // sender pauses until the result side has drained
        byte_in.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);

        rnd_start   = bytes_sent;
        found_start = frames_found;
        while ((bytes_sent - rnd_start < RANDOM_BYTES || frames_found - found_start < 40)
               && bytes_sent - rnd_start < 20 * RANDOM_BYTES)
        begin
            if ($urandom_range(15) == 0)
                quiet = ~quiet;
            k = $urandom_range(99);
            if (k < 70)
                send_frame(($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24),
                           6'($urandom), 12'($urandom), 1'b0, 1'b1, 0);
            else if (k < 80)
                send_frame($urandom_range(24), 6'($urandom), 12'($urandom), 1'b1, 1'b1, 0);
            else if (k < 90)
                send_junk($urandom_range(5, 1), 1'b1);
            else
                send_frame($urandom_range(24), 6'($urandom), 12'($urandom), 1'b0, 1'b1,
                           $urandom_range(8, 1));
        end
        quiet = 1'b0;

        byte_in.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d stream bytes; %0d frame descriptors checked (directed and random).",
                 bytes_sent, frames_checked);
        if (errors == 0 && frames_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rtcm_pkg.sv
rtl/rtcm_byte_if.sv
rtl/rtcm_frame_if.sv
rtl/rtcm_store.sv
rtl/rtcm_crc.sv
rtl/rtcm3_frame_sync_crc24q_top.sv
rtl/rtcm_chk.sv
tb/testbench.sv
